FILE: hdl/tadc_pkg.sv
// tadc_pkg: types, constants and the degree table for the thermistor converter
// no dependencies; used by tadc_ctrl, tadc_dp and the top level
`timescale 1ns / 1ps

package tadc_pkg;

  localparam int TABLE_ENTRIES = 100;
  localparam int FRAC_BITS_DEF = 8;
  localparam int SAMPLE_BITS_DEF = 12;
  localparam int SAMPLE_MAX_BITS = 16;
  localparam int ROM_BITS = 12;
  localparam int TEMP_BITS = 15;
  localparam int SEG_BITS = $clog2(TABLE_ENTRIES - 1);
  localparam int CNT_BITS = 5;

  typedef logic [SEG_BITS-1:0] seg_t;
  typedef logic [ROM_BITS-1:0] code_t;
  typedef logic [CNT_BITS-1:0] cnt_t;

  typedef enum logic [1:0] {
    FLAG_IN   = 2'd0,
    FLAG_LOW  = 2'd1,
    FLAG_HIGH = 2'd2
  } range_flag_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FETCH,
    ST_DINIT,
    ST_DIV,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic search_step;
    logic fetch;
    logic div_init;
    logic div_step;
    logic out_load;
    cnt_t cnt;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clamped;
    logic out_free;
  } status_t;

  localparam code_t DEG_ROM [TABLE_ENTRIES] = '{
    12'd961,  12'd999,  12'd1038, 12'd1077, 12'd1117, 12'd1158, 12'd1199, 12'd1241,
    12'd1284, 12'd1327, 12'd1370, 12'd1414, 12'd1458, 12'd1503, 12'd1548, 12'd1593,
    12'd1638, 12'd1684, 12'd1729, 12'd1775, 12'd1821, 12'd1866, 12'd1912, 12'd1957,
    12'd2003, 12'd2048, 12'd2092, 12'd2137, 12'd2181, 12'd2224, 12'd2268, 12'd2311,
    12'd2353, 12'd2395, 12'd2436, 12'd2477, 12'd2517, 12'd2557, 12'd2596, 12'd2634,
    12'd2672, 12'd2709, 12'd2745, 12'd2781, 12'd2816, 12'd2850, 12'd2884, 12'd2916,
    12'd2949, 12'd2980, 12'd3011, 12'd3041, 12'd3070, 12'd3099, 12'd3127, 12'd3154,
    12'd3180, 12'd3206, 12'd3231, 12'd3256, 12'd3280, 12'd3303, 12'd3326, 12'd3348,
    12'd3369, 12'd3390, 12'd3410, 12'd3430, 12'd3449, 12'd3467, 12'd3485, 12'd3503,
    12'd3520, 12'd3537, 12'd3553, 12'd3568, 12'd3583, 12'd3598, 12'd3612, 12'd3626,
    12'd3639, 12'd3652, 12'd3665, 12'd3677, 12'd3689, 12'd3700, 12'd3712, 12'd3722,
    12'd3733, 12'd3743, 12'd3753, 12'd3762, 12'd3772, 12'd3781, 12'd3789, 12'd3798,
    12'd3806, 12'd3814, 12'd3822, 12'd3829
  };

  // out-of-range indices read as all ones
  function automatic code_t rom_at(input seg_t idx);
    code_t v;
    v = '1;
    if (int'(idx) < TABLE_ENTRIES) begin
      v = DEG_ROM[idx];
    end
    return v;
  endfunction

endpackage

FILE: hdl/tadc_ctrl.sv
// tadc_ctrl: sequencer for search, segment fetch and restoring division
// depends on tadc_pkg
`timescale 1ns / 1ps

module tadc_ctrl import tadc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t st,
  output cmd_t    cmd,
  output state_t  fsm_state
);

  state_t state, state_next;
  cnt_t   cnt, cnt_next;

  assign fsm_state = state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_SEARCH;
          cnt_next   = cnt_t'(SEG_BITS - 1);
        end
      end
      ST_SEARCH: begin
        if (st.clamped) begin
          state_next = ST_DONE;
        end else if (cnt == '0) begin
          state_next = ST_FETCH;
        end else begin
          cnt_next = cnt - cnt_t'(1);
        end
      end
      ST_FETCH: begin
        state_next = ST_DINIT;
      end
      ST_DINIT: begin
        state_next = ST_DIV;
        cnt_next   = cnt_t'(FRAC_BITS - 1);
      end
      ST_DIV: begin
        if (cnt == '0) begin
          state_next = ST_DONE;
        end else begin
          cnt_next = cnt - cnt_t'(1);
        end
      end
      ST_DONE: begin
        if (st.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd          = '0;
    cmd.cnt      = cnt;
    in_ready     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SEARCH: cmd.search_step = 1'b1;
      ST_FETCH:  cmd.fetch       = 1'b1;
      ST_DINIT:  cmd.div_init    = 1'b1;
      ST_DIV:    cmd.div_step    = 1'b1;
      ST_DONE:   cmd.out_load    = st.out_free;
      default: begin
      end
    endcase
  end

endmodule

FILE: hdl/tadc_dp.sv
// tadc_dp: sample and clamp registers, table search, divider and output register
// depends on tadc_pkg
`timescale 1ns / 1ps

module tadc_dp import tadc_pkg::*; #(
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  cmd_t                  cmd,
  output status_t               st,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [TEMP_BITS-1:0]  out_temp,
  output logic [1:0]            out_flag
);

  localparam int XW = SAMPLE_MAX_BITS;
  localparam int QW = FRAC_BITS + 1;
  localparam int SUM_W = 32;

  logic [XW-1:0] x;
  range_flag_t   flag;
  seg_t          seg;
  code_t         diff;
  code_t         den;
  code_t         rem;
  logic [QW-1:0] q;

  logic [XW-1:0]     x_in;
  seg_t              cand;
  logic              take;
  logic [ROM_BITS:0] rem2;
  logic [SUM_W-1:0]  temp_sum;

  assign x_in = XW'(sample);
  assign cand = seg | (seg_t'(1) << cmd.cnt);
  assign take = (int'(cand) <= TABLE_ENTRIES - 2) && (XW'(rom_at(cand)) < x);
  assign rem2 = {rem, 1'b0};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x   <= x_in;
      seg <= '0;
      if (x_in <= XW'(DEG_ROM[0])) begin
        flag <= FLAG_LOW;
      end else if (x_in >= XW'(DEG_ROM[TABLE_ENTRIES-1])) begin
        flag <= FLAG_HIGH;
      end else begin
        flag <= FLAG_IN;
      end
    end
    // largest segment whose lower code is below the sample
    if (cmd.search_step && take) begin
      seg <= cand;
    end
    if (cmd.fetch) begin
      diff <= code_t'(x) - rom_at(seg);
      den  <= rom_at(seg + seg_t'(1)) - rom_at(seg);
    end
    // integer bit of the quotient is one only when the sample hits the upper code
    if (cmd.div_init) begin
      if (diff >= den) begin
        rem <= diff - den;
        q   <= QW'(1);
      end else begin
        rem <= diff;
        q   <= '0;
      end
    end
    if (cmd.div_step) begin
      if (rem2 >= {1'b0, den}) begin
        rem <= code_t'(rem2 - {1'b0, den});
        q   <= {q[QW-2:0], 1'b1};
      end else begin
        rem <= code_t'(rem2);
        q   <= {q[QW-2:0], 1'b0};
      end
    end
  end

  assign st.clamped  = (flag != FLAG_IN);
  assign st.out_free = !out_valid || out_ready;

  always_comb begin
    temp_sum = '0;
    case (flag)
      FLAG_LOW:  temp_sum = '0;
      FLAG_HIGH: temp_sum = SUM_W'(TABLE_ENTRIES - 1) << FRAC_BITS;
      default:   temp_sum = (SUM_W'(seg) << FRAC_BITS) + SUM_W'(q);
    endcase
  end

  // output register, parts the result from the next item's work
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_temp <= temp_sum[TEMP_BITS-1:0];
      out_flag <= flag;
    end
  end

endmodule

FILE: hdl/thermistor_adc_to_temperature_top.sv
// Usage of thermistor_adc_to_temperature_top:
// one converter sample in on the s_axis group (tdata bits [SAMPLE_BITS-1:0]),
// one temperature out on the m_axis group, degrees times 2^FRAC_BITS in
// tdata[14:0] and the range flag in tuser[1:0] (0 in range, 1 clamped low,
// 2 clamped high).
// An in-range sample is searched in the degree table one index bit a cycle,
// the segment codes are fetched, the divider is primed and then runs one
// quotient bit a cycle; a clamped sample skips the divider.
// One item is worked at a time; the next is accepted once the previous
// result is in the output register, so the item rate is set by the search
// and the bit-serial divider.
// The output register holds a result while the receiver stalls and the next
// item is still accepted and worked; it waits for the register to free up.
// Reset (rst, synchronous) returns the sequencer to idle and drops tvalid.
// depends on tadc_pkg, tadc_ctrl, tadc_dp
`timescale 1ns / 1ps

module thermistor_adc_to_temperature_top import tadc_pkg::*; #(
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [11:0] adc_sample, [15:12] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [14:0] temperature_q8, [15] zero
  output logic [1:0]  m_axis_tuser   // [1:0] range_flag
);

  cmd_t                 cmd;
  status_t              st;
  state_t               state;
  logic [TEMP_BITS-1:0] temp;

  tadc_ctrl #(
    .FRAC_BITS(FRAC_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .st        (st),
    .cmd       (cmd),
    .fsm_state (state)
  );

  tadc_dp #(
    .FRAC_BITS  (FRAC_BITS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .sample    (s_axis_tdata[SAMPLE_BITS-1:0]),
    .cmd       (cmd),
    .st        (st),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_temp  (temp),
    .out_flag  (m_axis_tuser)
  );

  assign m_axis_tdata = 16'(temp);

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready == (state == ST_IDLE))
    else $error("input ready outside idle");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second item taken while one is in work");

  a_flag_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tuser != 2'd3)
    else $error("invalid range flag");

  a_low_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == FLAG_LOW) |-> m_axis_tdata == 16'd0)
    else $error("clamped low result not zero");
`endif

endmodule

FILE: tb/thermistor_adc_to_temperature_top_tb.sv
// testbench for thermistor_adc_to_temperature_top: directed and random adc codes,
// checked against an in-bench table interpolation with random stalls on both sides
// depends on tadc_pkg and the top level with its sub-blocks
`timescale 1ns / 1ps

module thermistor_adc_to_temperature_top_tb;
  import tadc_pkg::*;

  localparam int N_DEG = 100;
  localparam int Q_BITS = 8;
  localparam int RANDOM_ITEMS = 1250;
  localparam int MAX_IDLE = 14;
  localparam int DRAIN_CYCLES = 40;
  localparam int TIMEOUT_NS = 12_000_000;

  // degree calibration codes, kept apart from the rtl copy
  localparam logic [11:0] DEG_CODES [N_DEG] = '{
    12'd961,  12'd999,  12'd1038, 12'd1077, 12'd1117, 12'd1158, 12'd1199, 12'd1241,
    12'd1284, 12'd1327, 12'd1370, 12'd1414, 12'd1458, 12'd1503, 12'd1548, 12'd1593,
    12'd1638, 12'd1684, 12'd1729, 12'd1775, 12'd1821, 12'd1866, 12'd1912, 12'd1957,
    12'd2003, 12'd2048, 12'd2092, 12'd2137, 12'd2181, 12'd2224, 12'd2268, 12'd2311,
    12'd2353, 12'd2395, 12'd2436, 12'd2477, 12'd2517, 12'd2557, 12'd2596, 12'd2634,
    12'd2672, 12'd2709, 12'd2745, 12'd2781, 12'd2816, 12'd2850, 12'd2884, 12'd2916,
    12'd2949, 12'd2980, 12'd3011, 12'd3041, 12'd3070, 12'd3099, 12'd3127, 12'd3154,
    12'd3180, 12'd3206, 12'd3231, 12'd3256, 12'd3280, 12'd3303, 12'd3326, 12'd3348,
    12'd3369, 12'd3390, 12'd3410, 12'd3430, 12'd3449, 12'd3467, 12'd3485, 12'd3503,
    12'd3520, 12'd3537, 12'd3553, 12'd3568, 12'd3583, 12'd3598, 12'd3612, 12'd3626,
    12'd3639, 12'd3652, 12'd3665, 12'd3677, 12'd3689, 12'd3700, 12'd3712, 12'd3722,
    12'd3733, 12'd3743, 12'd3753, 12'd3762, 12'd3772, 12'd3781, 12'd3789, 12'd3798,
    12'd3806, 12'd3814, 12'd3822, 12'd3829
  };

  typedef struct {
    logic [11:0] code;
    logic [14:0] temp;
    range_flag_t flag;
  } reading_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  reading_t pending_readings [$];
  int       mismatches = 0;
  bit       burst = 1'b0;
  int       hold_cycles = 0;

  thermistor_adc_to_temperature_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic reading_t predict_reading(input logic [11:0] code);
    reading_t r;
    int seg;
    int lo;
    int hi;
    int frac;
    r.code = code;
    seg = N_DEG - 2;
    frac = 0;
    if (code <= DEG_CODES[0]) begin
      r.temp = '0;
      r.flag = FLAG_LOW;
    end else if (code >= DEG_CODES[N_DEG-1]) begin
      r.temp = 15'((N_DEG - 1) << Q_BITS);
      r.flag = FLAG_HIGH;
    end else begin
      // first segment that brackets the code wins, so an exact entry gives a whole degree
      for (int k = 0; k < N_DEG - 1; k++) begin
        if (code >= DEG_CODES[k] && code <= DEG_CODES[k+1]) begin
          seg = k;
          break;
        end
      end
      lo = int'(DEG_CODES[seg]);
      hi = int'(DEG_CODES[seg+1]);
      if (hi > lo) begin
        frac = ((int'(code) - lo) << Q_BITS) / (hi - lo);
      end
      r.temp = 15'((seg << Q_BITS) + frac);
      r.flag = FLAG_IN;
    end
    return r;
  endfunction

  // called at a falling edge; returns at the falling edge after the item is taken
  task automatic send_adc(input logic [11:0] code);
    int gap;
    gap = burst ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= {4'b0000, 12'($urandom)};
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, code};
    do @(posedge clk); while (!s_axis_tready);
    pending_readings.push_back(predict_reading(code));
    @(negedge clk);
  endtask

  // called at a falling edge; the sender goes quiet until every result is back
  task automatic wait_all_results();
    s_axis_tvalid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_clamp_edges();
    send_adc(12'd0);
    send_adc(12'd960);
    send_adc(12'd961);
    send_adc(12'd962);
    send_adc(12'd3828);
    send_adc(12'd3829);
    send_adc(12'd3830);
    send_adc(12'hFFF);
  endtask

  task automatic test_inner_entries();
    send_adc(DEG_CODES[1]);
    send_adc(DEG_CODES[50]);
    send_adc(DEG_CODES[98]);
    send_adc(12'd2025);
    send_adc(DEG_CODES[50] + 12'd1);
    send_adc(DEG_CODES[98] - 12'd1);
  endtask

  task automatic test_bit_patterns();
    send_adc(12'hAAA);
    send_adc(12'h555);
    send_adc(12'h800);
    send_adc(12'h7FF);
    send_adc(12'h001);
    send_adc(12'hF0F);
  endtask

  task automatic test_random_codes();
    int pick;
    logic [11:0] code;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 80 == 0) begin
        burst = ($urandom_range(0, 3) == 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        code = 12'($urandom_range(962, 3828));
      end else if (pick < 70) begin
        code = 12'(int'(DEG_CODES[$urandom_range(0, N_DEG - 1)]) + $urandom_range(0, 2) - 1);
      end else if (pick < 80) begin
        code = 12'($urandom_range(0, 961));
      end else if (pick < 90) begin
        code = 12'($urandom_range(3829, 4095));
      end else begin
        code = 12'($urandom);
      end
      send_adc(code);
    end
    burst = 1'b0;
  endtask

  // receiver holds off while items keep coming, so the block stalls its input
  task automatic test_output_backpressure();
    hold_cycles = 300;
    burst = 1'b1;
    for (int i = 0; i < 10; i++) begin
      send_adc(12'($urandom_range(900, 3900)));
    end
    burst = 1'b0;
  endtask

  task automatic test_drain_pause();
    for (int i = 0; i < 4; i++) begin
      send_adc(12'($urandom));
    end
    wait_all_results();
    for (int i = 0; i < 4; i++) begin
      send_adc(12'($urandom_range(962, 3828)));
    end
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_clamp_edges();
    test_inner_entries();
    test_bit_patterns();
    test_output_backpressure();
    test_drain_pause();
    test_random_codes();

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // receiver: one stall drawn per item, or a long hold when one is asked for
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      if (hold_cycles > 0) begin
        stall = hold_cycles;
        hold_cycles = 0;
      end else begin
        stall = burst ? 0 : $urandom_range(0, MAX_IDLE);
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    reading_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_readings.size() == 0) begin
        if (mismatches < 10) begin
          $display("unexpected item: temp %0d flag %0d", m_axis_tdata[14:0], m_axis_tuser);
        end
        mismatches++;
      end else begin
        want = pending_readings.pop_front();
        if (m_axis_tdata[14:0] !== want.temp || m_axis_tuser !== want.flag) begin
          if (mismatches < 10) begin
            $display("mismatch for code %0d: expected temp %0d flag %0d, got temp %0d flag %0d",
                     want.code, want.temp, want.flag, m_axis_tdata[14:0], m_axis_tuser);
          end
          mismatches++;
        end
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: sim.f
hdl/tadc_pkg.sv
hdl/tadc_ctrl.sv
hdl/tadc_dp.sv
hdl/thermistor_adc_to_temperature_top.sv
tb/thermistor_adc_to_temperature_top_tb.sv
